[design/nv12b_pkg.sv]
// shared types and constants for the nv12 pixel to bgr unit
`timescale 1ns / 1ps
`default_nettype none

package nv12b_pkg;

  localparam int LUMA_W  = 8;
  localparam int CHAN_W  = 8;
  localparam int POS_W   = 12;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_W  = 26;
  localparam int CHROMA_W = 9;
  localparam int SUM_W   = 27;
  localparam int Q16_SHIFT = 16;
  localparam int COEF_W  = 19;

  localparam logic signed [COEF_W-1:0] K_RV = 19'sd89831;
  localparam logic signed [COEF_W-1:0] K_GU = 19'sd22127;
  localparam logic signed [COEF_W-1:0] K_GV = 19'sd45744;
  localparam logic signed [COEF_W-1:0] K_BU = 19'sd113538;

  localparam logic [LUMA_W-1:0] CHROMA_OFFSET = 8'd128;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

`default_nettype wire

[design/nv12_pixel_to_bgr_unit.sv]
// top level: nv12 pixel to bgr conversion with bottom-up frame address
// an accepted request passes through register stages one to four to the output
// throughput: one pixel per cycle while out_ready is high; the colour and
//   address pipelines have four register stages each (one multiply stage each)
// each stage holds only while the stage after it is full and stalled
// reset: pipeline empty, frame_width 640, frame_height 480
`timescale 1ns / 1ps
`default_nettype none

module nv12_pixel_to_bgr_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nv12b_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nv12b_pkg::CFG_W-1:0]       cfg_data,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire logic [nv12b_pkg::LUMA_W-1:0]      in_luma,
  input  wire logic [nv12b_pkg::LUMA_W-1:0]      in_chroma_u,
  input  wire logic [nv12b_pkg::LUMA_W-1:0]      in_chroma_v,
  input  wire logic [nv12b_pkg::POS_W-1:0]       in_pixel_row,
  input  wire logic [nv12b_pkg::POS_W-1:0]       in_pixel_col,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic      [nv12b_pkg::CHAN_W-1:0]      out_blue,
  output logic      [nv12b_pkg::CHAN_W-1:0]      out_green,
  output logic      [nv12b_pkg::CHAN_W-1:0]      out_red,
  output logic      [nv12b_pkg::ADDR_W-1:0]      out_dest_address
);
  import nv12b_pkg::*;

  logic [CFG_W-1:0]  width_r, width_nxt;
  logic [CFG_W-1:0]  height_r, height_nxt;
  logic [CFG_W-1:0]  lim_width, lim_height;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic              rdy1, rdy2, rdy3, rdy4;
  stage_en_t         en;

  logic [ADDR_W-1:0] line1_r;
  logic [POS_W-1:0]  col1_r, col2_r;
  logic [ADDR_W-1:0] prod2_r;
  logic [ADDR_W-1:0] idx3_r;
  logic [ADDR_W-1:0] addr4_r;

  // register write limits
  always_comb begin
    lim_width = cfg_data;
    if (cfg_data == '0) begin
      lim_width = CFG_W'(1);
    end else if ({1'b0, cfg_data} > (CFG_W+1)'(MAX_WIDTH)) begin
      lim_width = CFG_W'(MAX_WIDTH);
    end
    lim_height = cfg_data;
    if (cfg_data == '0) begin
      lim_height = CFG_W'(1);
    end else if ({1'b0, cfg_data} > (CFG_W+1)'(MAX_HEIGHT)) begin
      lim_height = CFG_W'(MAX_HEIGHT);
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_nxt  = lim_width;
        CFG_IDX_HEIGHT: height_nxt = lim_height;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // stage advance, bubbles collapse
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // address pipeline, all modulo 2^26
  always_ff @(posedge clk) begin
    if (rdy1) begin
      line1_r <= ADDR_W'(height_r) - ADDR_W'(1) - ADDR_W'(in_pixel_row);
      col1_r  <= in_pixel_col;
    end
    if (rdy2) begin
      prod2_r <= line1_r * ADDR_W'(width_r);
      col2_r  <= col1_r;
    end
    if (rdy3) begin
      idx3_r <= prod2_r + ADDR_W'(col2_r);
    end
    if (rdy4) begin
      addr4_r <= idx3_r + {idx3_r[ADDR_W-2:0], 1'b0};
    end
  end

  nv12b_colour u_colour (
    .clk      (clk),
    .en       (en),
    .luma     (in_luma),
    .chroma_u (in_chroma_u),
    .chroma_v (in_chroma_v),
    .blue     (out_blue),
    .green    (out_green),
    .red      (out_red)
  );

  assign out_valid        = v4_r;
  assign out_dest_address = addr4_r;

  // accepted request reaches stage one
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted request missing from stage one");

  // stalled output keeps both full tail stages
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && v4_r && !out_ready |=> v3_r && v4_r)
    else $error("request lost during output stall");

  // frame registers stay within limits
  a_cfg_range: assert property (@(posedge clk) disable iff (!rst_n)
    width_r != '0 && height_r != '0 &&
    {1'b0, width_r} <= (CFG_W+1)'(MAX_WIDTH) &&
    {1'b0, height_r} <= (CFG_W+1)'(MAX_HEIGHT))
    else $error("frame register out of range");

  // no request taken while the first stage is full and blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && v4_r && !out_ready |-> !in_ready)
    else $error("request accepted into full pipeline");

endmodule

`default_nettype wire

[design/nv12b_colour.sv]
// four stage yuv to bgr colour arithmetic with clamping
`timescale 1ns / 1ps
`default_nettype none

module nv12b_colour (
  input  wire                                clk,
  input  wire nv12b_pkg::stage_en_t          en,
  input  wire logic [nv12b_pkg::LUMA_W-1:0]  luma,
  input  wire logic [nv12b_pkg::LUMA_W-1:0]  chroma_u,
  input  wire logic [nv12b_pkg::LUMA_W-1:0]  chroma_v,
  output logic      [nv12b_pkg::CHAN_W-1:0]  blue,
  output logic      [nv12b_pkg::CHAN_W-1:0]  green,
  output logic      [nv12b_pkg::CHAN_W-1:0]  red
);
  import nv12b_pkg::*;

  logic        [LUMA_W-1:0]   y1_r;
  logic signed [CHROMA_W-1:0] u1_r, v1_r;
  logic        [LUMA_W-1:0]   y2_r;
  logic signed [SUM_W-1:0]    bu2_r, gu2_r, gv2_r, rv2_r;
  logic signed [SUM_W-1:0]    bs3_r, gs3_r, rs3_r;
  logic        [CHAN_W-1:0]   b4_r, g4_r, r4_r;
  logic signed [SUM_W-1:0]    base2;

  function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
    logic [CHAN_W-1:0] res;
    if (s[SUM_W-1] || s == '0) begin
      res = '0;
    end else if (s[SUM_W-1:Q16_SHIFT+CHAN_W] != '0) begin
      res = '1;
    end else begin
      res = s[Q16_SHIFT+CHAN_W-1:Q16_SHIFT];
    end
    return res;
  endfunction

  // remove chroma offset
  always_ff @(posedge clk) begin
    if (en.s1) begin
      y1_r <= luma;
      u1_r <= $signed({1'b0, chroma_u}) - $signed({1'b0, CHROMA_OFFSET});
      v1_r <= $signed({1'b0, chroma_v}) - $signed({1'b0, CHROMA_OFFSET});
    end
  end

  // coefficient products
  always_ff @(posedge clk) begin
    if (en.s2) begin
      y2_r  <= y1_r;
      bu2_r <= SUM_W'(K_BU) * SUM_W'(u1_r);
      gu2_r <= SUM_W'(K_GU) * SUM_W'(u1_r);
      gv2_r <= SUM_W'(K_GV) * SUM_W'(v1_r);
      rv2_r <= SUM_W'(K_RV) * SUM_W'(v1_r);
    end
  end

  assign base2 = $signed({{(SUM_W-LUMA_W-Q16_SHIFT){1'b0}}, y2_r, {Q16_SHIFT{1'b0}}});

  // q16 channel sums
  always_ff @(posedge clk) begin
    if (en.s3) begin
      bs3_r <= base2 + bu2_r;
      gs3_r <= base2 - gu2_r - gv2_r;
      rs3_r <= base2 + rv2_r;
    end
  end

  // truncate and clamp to a byte
  always_ff @(posedge clk) begin
    if (en.s4) begin
      b4_r <= clamp_chan(bs3_r);
      g4_r <= clamp_chan(gs3_r);
      r4_r <= clamp_chan(rs3_r);
    end
  end

  assign blue  = b4_r;
  assign green = g4_r;
  assign red   = r4_r;

endmodule

`default_nettype wire

[bench/nv12_pixel_to_bgr_unit_tb.sv]
// testbench for the nv12 pixel to bgr unit: scoreboarded random and directed pixel streams
`timescale 1ns / 1ps

module nv12_pixel_to_bgr_unit_tb;
  import nv12b_pkg::*;

  localparam int  PIXELS_PER_PHASE_MAX = 4096;
  localparam int  LIMIT_W              = 4096;
  localparam int  LIMIT_H              = 4096;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  localparam longint Q16_UNIT  = 65536;
  localparam longint COEF_R_V  = 89831;
  localparam longint COEF_G_U  = 22127;
  localparam longint COEF_G_V  = 45744;
  localparam longint COEF_B_U  = 113538;
  localparam longint UV_OFFSET = 128;
  localparam int     DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic [LUMA_W-1:0] chroma_u;
    logic [LUMA_W-1:0] chroma_v;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [ADDR_W-1:0] addr;
  } bgr_t;

  class bgr_scoreboard;
    logic [CFG_W-1:0] frame_w;
    logic [CFG_W-1:0] frame_h;
    bgr_t             expected_q[$];
    int               failures;
    int               checked;
    int               accepted;

    function new();
      frame_w   = WIDTH_RESET;
      frame_h   = HEIGHT_RESET;
      failures  = 0;
      checked   = 0;
      accepted  = 0;
    endfunction

    function logic [CFG_W-1:0] saturate(logic [CFG_W-1:0] raw, int limit);
      if (raw == 0) return CFG_W'(1);
      if (int'(raw) > limit) return CFG_W'(limit);
      return raw;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_IDX_WIDTH) frame_w = saturate(data, LIMIT_W);
      else if (idx == CFG_IDX_HEIGHT) frame_h = saturate(data, LIMIT_H);
    endfunction

    function logic [CHAN_W-1:0] clamp_q16(longint s);
      longint whole;
      if (s <= 0) return '0;
      whole = s / Q16_UNIT;
      if (whole > 255) return 8'd255;
      return whole[CHAN_W-1:0];
    endfunction

    function bgr_t convert(pixel_t p);
      longint      y;
      longint      cu;
      longint      cv;
      logic [63:0] line;
      logic [63:0] full_addr;
      bgr_t        r;
      y  = longint'(p.luma) * Q16_UNIT;
      cu = longint'(p.chroma_u) - UV_OFFSET;
      cv = longint'(p.chroma_v) - UV_OFFSET;
      r.blue  = clamp_q16(y + COEF_B_U * cu);
      r.green = clamp_q16(y - COEF_G_U * cu - COEF_G_V * cv);
      r.red   = clamp_q16(y + COEF_R_V * cv);
      line = 64'(frame_h) - 64'd1 - 64'(p.row);
      full_addr = (line * 64'(frame_w) + 64'(p.col)) * 64'd3;
      r.addr = full_addr[ADDR_W-1:0];
      return r;
    endfunction

    function void note_pixel(pixel_t p);
      expected_q.insert(expected_q.size(), convert(p));
      accepted++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      failures++;
    endtask

    task check_pixel(bgr_t got);
      bgr_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, blue", got.blue, -1);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
      if (got.green !== want.green) report_mismatch("green", got.green, want.green);
      if (got.red !== want.red) report_mismatch("red", got.red, want.red);
      if (got.addr !== want.addr) report_mismatch("dest_address", got.addr, want.addr);
    endtask

    task close_out();
      if (expected_q.size() != 0)
        report_mismatch("results never returned", 0, expected_q.size());
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [LUMA_W-1:0]    in_luma;
  logic [LUMA_W-1:0]    in_chroma_u;
  logic [LUMA_W-1:0]    in_chroma_v;
  logic [POS_W-1:0]     in_pixel_row;
  logic [POS_W-1:0]     in_pixel_col;
  logic                 out_valid;
  logic                 out_ready;
  logic [CHAN_W-1:0]    out_blue;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_red;
  logic [ADDR_W-1:0]    out_dest_address;

  bgr_scoreboard sb;
  bit            steady;
  int            settings_run;

  nv12_pixel_to_bgr_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_luma          (in_luma),
    .in_chroma_u      (in_chroma_u),
    .in_chroma_v      (in_chroma_v),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_col     (in_pixel_col),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blue         (out_blue),
    .out_green        (out_green),
    .out_red          (out_red),
    .out_dest_address (out_dest_address)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random back-pressure, checked at the rising edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_pixel('{out_blue, out_green, out_red, out_dest_address});
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.write_reg(idx, data);
  endtask

  task set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    write_reg(CFG_IDX_WIDTH, w);
    write_reg(CFG_IDX_HEIGHT, h);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  task send_pixel(pixel_t p);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_luma      <= p.luma;
    in_chroma_u  <= p.chroma_u;
    in_chroma_v  <= p.chroma_v;
    in_pixel_row <= p.row;
    in_pixel_col <= p.col;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_pixel(p);
  endtask

  task send_fields(int y, int u, int v, int row, int col);
    send_pixel('{LUMA_W'(y), LUMA_W'(u), LUMA_W'(v), POS_W'(row), POS_W'(col)});
  endtask

  function pixel_t random_pixel();
    pixel_t p;
    p.luma     = LUMA_W'($urandom_range(255));
    p.chroma_u = LUMA_W'($urandom_range(255));
    p.chroma_v = LUMA_W'($urandom_range(255));
    // mostly inside the frame, sometimes anywhere in the 12-bit range
    if ($urandom_range(99) < 80) begin
      p.row = POS_W'($urandom_range(int'(sb.frame_h) - 1));
      p.col = POS_W'($urandom_range(int'(sb.frame_w) - 1));
    end else begin
      p.row = POS_W'($urandom_range(PIXELS_PER_PHASE_MAX - 1));
      p.col = POS_W'($urandom_range(PIXELS_PER_PHASE_MAX - 1));
    end
    return p;
  endfunction

  task send_random(int n);
    repeat (n) send_pixel(random_pixel());
  endtask

  task settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb           = new();
    steady       = 1'b0;
    settings_run = 1;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_IDX_WIDTH;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_luma      = '0;
    in_chroma_u  = '0;
    in_chroma_v  = '0;
    in_pixel_row = '0;
    in_pixel_col = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset frame size, corner colours and positions
    send_fields(0, 128, 128, 0, 0);
    send_fields(255, 128, 128, 479, 639);
    send_fields(0, 0, 0, 0, 639);
    send_fields(255, 255, 255, 479, 0);
    send_fields(255, 0, 0, 100, 200);
    send_fields(0, 255, 255, 1, 1);
    send_fields(0, 0, 255, 2, 3);
    send_fields(0, 255, 0, 3, 2);
    send_fields(255, 0, 255, 200, 100);
    send_fields(255, 255, 0, 300, 500);
    send_fields(128, 128, 128, 240, 320);
    send_fields(1, 127, 129, 5, 5);
    send_fields(16, 129, 127, 6, 7);
    send_fields(235, 240, 16, 7, 6);
    // positions outside the frame wrap the address
    send_fields(77, 50, 200, 480, 640);
    send_fields(200, 200, 50, 4095, 4095);
    send_fields(90, 10, 240, 0, 4095);
    send_fields(170, 240, 10, 4095, 0);
    send_random(100);
    settle();

    set_frame(13'd1, 13'd1);
    send_fields(255, 255, 0, 0, 0);
    send_fields(0, 0, 255, 4095, 4095);
    send_random(80);
    settle();

    // largest frame with no idling on either side
    set_frame(13'd4096, 13'd4096);
    steady = 1'b1;
    send_fields(255, 128, 128, 0, 0);
    send_fields(0, 128, 128, 4095, 4095);
    send_random(80);
    settle();
    steady = 1'b0;

    // zero and oversize writes saturate
    set_frame(13'd0, 13'd8191);
    send_random(60);
    settle();

    set_frame(13'd4097, 13'd2);
    write_reg(CFG_IDX_SPARE_LO, 13'($urandom_range(8191)));
    write_reg(CFG_IDX_SPARE_HI, 13'd8191);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_random(60);
    settle();

    repeat (3) begin
      if ($urandom_range(3) == 0)
        set_frame(13'($urandom_range(8191)), 13'($urandom_range(8191)));
      else
        set_frame(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      send_random(70);
      settle();
    end

    sb.close_out();
    $display("covered %0d pixels under %0d frame sizes, %0d results compared",
             sb.accepted, settings_run, sb.checked);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
